FILE: rtl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define KECD_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// condition in one cycle implies a property in the next
`define KECD_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: rtl/kecd_pkg.sv
// package for the key event combo detector: codes, sizes and types
package kecd_pkg;

    localparam int QUEUE_DEPTH = 256;
    localparam int Q_AW        = $clog2(QUEUE_DEPTH);
    localparam int Q_CW        = $clog2(QUEUE_DEPTH + 1);

    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = ((11 + Q_CW + 7) / 8) * 8;

    localparam logic [Q_CW-1:0] DEPTH_C    = Q_CW'(QUEUE_DEPTH);
    localparam logic [Q_AW-1:0] LAST_ADDR  = Q_AW'(QUEUE_DEPTH - 1);

    localparam logic [9:0] KEY_NONE     = 10'd1023;
    localparam logic [9:0] KEY_MAX_CODE = 10'd767;
    localparam logic [9:0] K_HOME       = 10'd102;
    localparam logic [9:0] K_UP         = 10'd103;
    localparam logic [9:0] K_DOWN       = 10'd108;
    localparam logic [9:0] K_VOLDOWN    = 10'd114;
    localparam logic [9:0] K_VOLUP      = 10'd115;
    localparam logic [9:0] K_POWER      = 10'd116;

    localparam logic [1:0] CFG_REBOOT_EN  = 2'd0;
    localparam logic [1:0] CFG_LONG_TICKS = 2'd1;
    localparam logic [1:0] CFG_MOTION_THR = 2'd2;
    localparam logic [1:0] CFG_REPEAT_TGT = 2'd3;

    typedef enum logic [2:0] {
        ACT_KEY    = 3'd0,
        ACT_MOTION = 3'd1,
        ACT_TICK   = 3'd2,
        ACT_TAKE   = 3'd3,
        ACT_FLUSH  = 3'd4
    } t_action;

    typedef enum logic [3:0] {
        OC_NONE    = 4'd0,
        OC_TOGGLE  = 4'd1,
        OC_REBOOT  = 4'd2,
        OC_MOUNT   = 4'd3,
        OC_QUEUED  = 4'd4,
        OC_DROPPED = 4'd5,
        OC_LONG    = 4'd6,
        OC_TAKEN   = 4'd7,
        OC_EMPTY   = 4'd8
    } t_outcome;

endpackage

FILE: rtl/key_event_combo_detector.sv
// key event combo detector: key registration, long press, trackball keys, key queue
//
// channel   dir  tdata (low bit up)                          tuser
// s_axis    in   key[9:0] pressed[10] motion_delta[26:11]    action[2:0]
// m_axis    out  result_key[9:0] was_long[10] queue_fill[19:11] outcome[3:0]
// cfg       in   i_cfg_we, i_cfg_idx, i_cfg_wdata (write only)
//
// an accepted item passes through the input register, then the result register
// one item per cycle sustained while m_axis_tready is high; the key queue memory has one write and one read port
// the head entry is read ahead into a register, so a take finds the head key already there
// synchronous active-low reset; no clearing pass, queue entries are only read once written
// a stalled output holds the result; the input register takes one more item, then tready drops
`include "assert_macros.svh"

module key_event_combo_detector (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // key[9:0], pressed[10], motion_delta[26:11]
    input  logic [kecd_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // action[2:0]
    input  logic [2:0]                       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // result_key[9:0], was_long[10], queue_fill[19:11]
    output logic [kecd_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // outcome[3:0]
    output logic [3:0]                       m_axis_tuser,
    input  logic                             i_cfg_we,
    input  logic [1:0]                       i_cfg_idx,
    input  logic [15:0]                      i_cfg_wdata
);

    localparam int AW = kecd_pkg::Q_AW;
    localparam int CW = kecd_pkg::Q_CW;

    // configuration
    logic        r_reboot_en;
    logic [15:0] r_long_ticks;
    logic [7:0]  r_motion_thr;
    logic [3:0]  r_repeat_tgt;

    // input register
    logic                r_in_valid;
    kecd_pkg::t_action   r_in_action;
    logic [9:0]          r_in_key;
    logic                r_in_pressed;
    logic [15:0]         r_in_delta;

    // block state
    logic                r_power_held;
    logic [9:0]          r_last_down;
    logic                r_long_flag;
    logic [15:0]         r_hold_timer;
    logic signed [17:0]  r_motion_sum;
    logic [3:0]          r_power_run;
    logic [3:0]          r_alt_run;
    logic [9:0]          r_prev_key;
    logic [AW-1:0]       r_fifo_head;
    logic [CW-1:0]       r_fifo_count;
    logic [9:0]          r_mem [kecd_pkg::QUEUE_DEPTH];
    logic [9:0]          r_head_q;

    // result register
    logic                r_out_valid;
    kecd_pkg::t_outcome  r_out_outcome;
    logic [9:0]          r_out_key;
    logic                r_out_long;
    logic [CW-1:0]       r_out_fill;

    logic                n_power_held;
    logic [9:0]          n_last_down;
    logic                n_long_flag;
    logic [15:0]         n_hold_timer;
    logic signed [17:0]  n_motion_sum;
    logic [3:0]          n_power_run;
    logic [3:0]          n_alt_run;
    logic [9:0]          n_prev_key;
    logic [AW-1:0]       n_fifo_head;
    logic [CW-1:0]       n_fifo_count;

    kecd_pkg::t_outcome  res_outcome;
    logic [9:0]          res_key;
    logic                res_long;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [AW-1:0]       rd_addr;
    logic                adv;
    logic                s_acc;

    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    always_comb begin
        logic signed [17:0] sum_tmp;
        logic signed [17:0] thr_s;
        logic               do_ev;
        logic [9:0]         ev_key;
        logic               ev_down;
        logic               do_cls;
        logic [9:0]         cls_key;
        logic               cls_long;
        logic [3:0]         pr_inc;
        logic [3:0]         ar_inc;
        logic               pr_hit;
        logic               alt;
        logic [AW:0]        wsum;

        n_power_held = r_power_held;
        n_last_down  = r_last_down;
        n_long_flag  = r_long_flag;
        n_hold_timer = r_hold_timer;
        n_motion_sum = r_motion_sum;
        n_power_run  = r_power_run;
        n_alt_run    = r_alt_run;
        n_prev_key   = r_prev_key;
        n_fifo_head  = r_fifo_head;
        n_fifo_count = r_fifo_count;
        res_outcome  = kecd_pkg::OC_NONE;
        res_key      = '0;
        res_long     = 1'b0;
        mem_we       = 1'b0;
        do_ev        = 1'b0;
        ev_key       = r_in_key;
        ev_down      = r_in_pressed;
        do_cls       = 1'b0;
        cls_key      = r_in_key;
        cls_long     = 1'b0;
        pr_hit       = 1'b0;
        alt          = 1'b0;
        pr_inc       = (r_power_run == 4'hF) ? r_power_run : r_power_run + 4'd1;
        ar_inc       = (r_alt_run == 4'hF) ? r_alt_run : r_alt_run + 4'd1;
        sum_tmp      = r_motion_sum + {{2{r_in_delta[15]}}, r_in_delta};
        thr_s        = $signed({10'd0, r_motion_thr});
        wsum         = {1'b0, r_fifo_head} + (AW+1)'(r_fifo_count);
        mem_waddr    = (wsum >= (AW+1)'(kecd_pkg::QUEUE_DEPTH))
                       ? AW'(wsum - (AW+1)'(kecd_pkg::QUEUE_DEPTH)) : AW'(wsum);

        case (r_in_action)
            kecd_pkg::ACT_KEY: begin
                n_motion_sum = '0;
                if (r_in_key <= kecd_pkg::KEY_MAX_CODE) begin
                    do_ev = 1'b1;
                end
            end
            kecd_pkg::ACT_MOTION: begin
                if (sum_tmp > thr_s || sum_tmp < -thr_s) begin
                    // synthetic press and release of down or up
                    n_motion_sum = '0;
                    n_last_down  = kecd_pkg::KEY_NONE;
                    n_long_flag  = 1'b0;
                    n_hold_timer = '0;
                    do_cls       = 1'b1;
                    cls_key      = (sum_tmp > thr_s) ? kecd_pkg::K_DOWN : kecd_pkg::K_UP;
                end else begin
                    n_motion_sum = sum_tmp;
                end
            end
            kecd_pkg::ACT_TICK: begin
                if (r_last_down != kecd_pkg::KEY_NONE && !r_long_flag) begin
                    if (r_hold_timer != 16'hFFFF) begin
                        n_hold_timer = r_hold_timer + 16'd1;
                    end
                    if (n_hold_timer >= r_long_ticks) begin
                        n_long_flag = 1'b1;
                        res_outcome = kecd_pkg::OC_LONG;
                        res_key     = r_last_down;
                        res_long    = 1'b1;
                    end
                end
            end
            kecd_pkg::ACT_TAKE: begin
                if (r_fifo_count != '0) begin
                    res_outcome  = kecd_pkg::OC_TAKEN;
                    res_key      = r_head_q;
                    n_fifo_head  = (r_fifo_head == kecd_pkg::LAST_ADDR) ? '0
                                   : r_fifo_head + AW'(1);
                    n_fifo_count = r_fifo_count - CW'(1);
                end else begin
                    res_outcome = kecd_pkg::OC_EMPTY;
                end
            end
            kecd_pkg::ACT_FLUSH: begin
                n_fifo_count = '0;
            end
            default: begin
                res_outcome = kecd_pkg::OC_NONE;
            end
        endcase

        if (do_ev) begin
            if (ev_key == kecd_pkg::K_POWER) begin
                n_power_held = ev_down;
            end
            if (ev_down) begin
                n_last_down  = ev_key;
                n_long_flag  = 1'b0;
                n_hold_timer = '0;
            end else begin
                n_last_down = kecd_pkg::KEY_NONE;
                if (r_last_down == ev_key) begin
                    do_cls   = 1'b1;
                    cls_key  = ev_key;
                    cls_long = r_long_flag;
                end
            end
        end

        if (do_cls) begin
            res_key  = cls_key;
            res_long = cls_long;
            if ((n_power_held && cls_key == kecd_pkg::K_VOLUP) || cls_key == kecd_pkg::K_HOME) begin
                res_outcome = kecd_pkg::OC_TOGGLE;
            end else begin
                if (cls_key == kecd_pkg::K_POWER) begin
                    if (r_reboot_en) begin
                        n_power_run = pr_inc;
                        pr_hit      = (pr_inc >= r_repeat_tgt);
                    end
                end else begin
                    n_power_run = '0;
                end
                if (pr_hit) begin
                    res_outcome = kecd_pkg::OC_REBOOT;
                end else begin
                    alt = (cls_key == kecd_pkg::K_VOLUP &&
                           (r_prev_key == kecd_pkg::K_VOLDOWN || r_prev_key == kecd_pkg::KEY_NONE)) ||
                          (cls_key == kecd_pkg::K_VOLDOWN &&
                           (r_prev_key == kecd_pkg::K_VOLUP || r_prev_key == kecd_pkg::KEY_NONE));
                    if (alt && ar_inc >= r_repeat_tgt) begin
                        n_alt_run   = '0;
                        res_outcome = kecd_pkg::OC_MOUNT;
                    end else begin
                        n_alt_run  = alt ? ar_inc : 4'd0;
                        n_prev_key = cls_key;
                        if (r_fifo_count < kecd_pkg::DEPTH_C) begin
                            mem_we       = 1'b1;
                            n_fifo_count = r_fifo_count + CW'(1);
                            res_outcome  = kecd_pkg::OC_QUEUED;
                        end else begin
                            res_outcome = kecd_pkg::OC_DROPPED;
                        end
                    end
                end
            end
        end
    end

    assign rd_addr = adv ? n_fifo_head : r_fifo_head;

    // key queue memory with head read-ahead
    always_ff @(posedge i_clk) begin
        if (adv && mem_we) begin
            r_mem[mem_waddr] <= res_key;
        end
        if (adv && mem_we && mem_waddr == rd_addr) begin
            r_head_q <= res_key;
        end else begin
            r_head_q <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reboot_en  <= 1'b1;
            r_long_ticks <= 16'd750;
            r_motion_thr <= 8'd3;
            r_repeat_tgt <= 4'd7;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                kecd_pkg::CFG_REBOOT_EN:  r_reboot_en  <= i_cfg_wdata[0];
                kecd_pkg::CFG_LONG_TICKS: r_long_ticks <= i_cfg_wdata;
                kecd_pkg::CFG_MOTION_THR: r_motion_thr <= i_cfg_wdata[7:0];
                kecd_pkg::CFG_REPEAT_TGT: r_repeat_tgt <= i_cfg_wdata[3:0];
                default: r_reboot_en <= r_reboot_en;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_acc) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
        if (s_acc) begin
            r_in_action  <= kecd_pkg::t_action'(s_axis_tuser);
            r_in_key     <= s_axis_tdata[9:0];
            r_in_pressed <= s_axis_tdata[10];
            r_in_delta   <= s_axis_tdata[26:11];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_power_held <= 1'b0;
            r_last_down  <= kecd_pkg::KEY_NONE;
            r_long_flag  <= 1'b0;
            r_hold_timer <= '0;
            r_motion_sum <= '0;
            r_power_run  <= '0;
            r_alt_run    <= '0;
            r_prev_key   <= kecd_pkg::KEY_NONE;
            r_fifo_head  <= '0;
            r_fifo_count <= '0;
        end else if (adv) begin
            r_power_held <= n_power_held;
            r_last_down  <= n_last_down;
            r_long_flag  <= n_long_flag;
            r_hold_timer <= n_hold_timer;
            r_motion_sum <= n_motion_sum;
            r_power_run  <= n_power_run;
            r_alt_run    <= n_alt_run;
            r_prev_key   <= n_prev_key;
            r_fifo_head  <= n_fifo_head;
            r_fifo_count <= n_fifo_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (adv) begin
            r_out_outcome <= res_outcome;
            r_out_key     <= res_key;
            r_out_long    <= res_long;
            r_out_fill    <= n_fifo_count;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_outcome;
    assign m_axis_tdata  = kecd_pkg::M_TDATA_W'({r_out_fill, r_out_long, r_out_key});

    `KECD_ASSERT(a_fill_bound, r_fifo_count <= kecd_pkg::DEPTH_C, "queue fill above depth")
    `KECD_ASSERT(a_empty_fill, !(r_out_valid && r_out_outcome == kecd_pkg::OC_EMPTY) || r_out_fill == '0, "empty outcome with nonzero fill")
    `KECD_ASSERT_NEXT(a_timer_step, 1'b1, (r_hold_timer == $past(r_hold_timer) || r_hold_timer == '0 || r_hold_timer == $past(r_hold_timer) + 16'd1), "hold timer jumped")
    `KECD_ASSERT_NEXT(a_stall_state, r_in_valid && !adv, (r_fifo_count == $past(r_fifo_count) && r_fifo_head == $past(r_fifo_head)), "queue state moved while stalled")

endmodule
